// ===== design/lict_pkg.sv =====
`default_nettype none

package lict_pkg;

  // build-time settings
  localparam int unsigned CountWidth = 32;
  localparam logic [7:0] ControllerId = 8'd0;

  // action codes
  localparam logic [1:0] ActTick  = 2'd0;
  localparam logic [1:0] ActRead  = 2'd1;
  localparam logic [1:0] ActWrite = 2'd2;

  // register index (byte offset / 4)
  localparam logic [7:0] IdxId   = 8'h08;
  localparam logic [7:0] IdxEoi  = 8'h2C;
  localparam logic [7:0] IdxSvr  = 8'h3C;
  localparam logic [7:0] IdxLvt  = 8'hC8;
  localparam logic [7:0] IdxInit = 8'hE0;
  localparam logic [7:0] IdxCur  = 8'hE4;
  localparam logic [7:0] IdxDiv  = 8'hF8;

  // register field layout
  localparam int unsigned SvrEnableBit   = 8;
  localparam int unsigned LvtMaskBit     = 16;
  localparam int unsigned LvtPeriodicBit = 17;
  localparam logic [17:0] LvtKeep  = 18'h300FF;
  localparam logic [3:0]  DivKeep  = 4'hB;
  localparam logic [8:0]  SvrReset = 9'h0FF;
  localparam logic [17:0] LvtReset = 18'h10000;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
    logic [7:0]  irq_vector;
  } result_t;

  // prescaler divisor from the divide register, code = {bit3, bit1, bit0}
  function automatic logic [7:0] divisor(input logic [3:0] div);
    logic [2:0] code;
    code = {div[3], div[1:0]};
    if (code == 3'd7) begin
      return 8'd1;
    end
    return 8'd1 << (code + 3'd1);
  endfunction

endpackage

`default_nettype wire

// ===== design/local_interrupt_controller_timer_top.sv =====
// results are registered; throughput: one word per cycle while the skid
// register is empty; a two-entry output buffer (result register plus skid
// register) lets input take one more word during an output stall
// reset: synchronous, active high; svr = 0x0ff (disabled), lvt masked with
// vector zero, counts, divide, prescaler and pending flag cleared
`default_nettype none

module local_interrupt_controller_timer_top import lict_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  action,
  input  wire logic [7:0]  reg_index,
  input  wire logic [31:0] write_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      read_data,
  output logic             irq,
  output logic [7:0]       irq_vector
);

  // architectural timer state
  logic [8:0]            spurious_reg,      spurious_reg_next;
  logic [17:0]           timer_lvt,         timer_lvt_next;
  logic [CountWidth-1:0] initial_count,     initial_count_next;
  logic [CountWidth-1:0] current_count,     current_count_next;
  logic [3:0]            divide_setting,    divide_setting_next;
  logic [6:0]            prescale_count,    prescale_count_next;
  logic                  interrupt_pending, interrupt_pending_next;

  // output buffer: main result register and skid register
  result_t res_reg, skid_reg, res_next;
  logic    res_valid, skid_valid;

  logic push;
  logic res_load, skid_load, skid_move;

  // tick helpers
  logic [6:0]            pre_inc;
  logic [CountWidth-1:0] cnt_dec;
  logic [31:0]           rd;

  // input is held off only while the skid register holds a word
  assign in_ready = !skid_valid;
  assign push     = in_valid && in_ready;

  assign pre_inc = prescale_count + 7'd1;
  assign cnt_dec = current_count - CountWidth'(1);

  // next state and result word for the accepted input word
  always_comb begin
    spurious_reg_next      = spurious_reg;
    timer_lvt_next         = timer_lvt;
    initial_count_next     = initial_count;
    current_count_next     = current_count;
    divide_setting_next    = divide_setting;
    prescale_count_next    = prescale_count;
    interrupt_pending_next = interrupt_pending;
    rd                     = 32'd0;

    unique case (action)
      ActTick: begin
        // a stopped counter ignores ticks
        if (current_count != '0) begin
          if (pre_inc != 7'd0 && {1'b0, pre_inc} < divisor(divide_setting)) begin
            prescale_count_next = pre_inc;
          end else begin
            prescale_count_next = 7'd0;
            current_count_next  = cnt_dec;
            if (cnt_dec == '0) begin
              // reached zero: raise unless masked or software-disabled
              if (!timer_lvt[LvtMaskBit] && spurious_reg[SvrEnableBit]) begin
                interrupt_pending_next = 1'b1;
              end
              // periodic reload; a zero initial count simply stops
              if (timer_lvt[LvtPeriodicBit]) begin
                current_count_next = initial_count;
              end
            end
          end
        end
      end
      ActRead: begin
        unique case (reg_index)
          IdxId:   rd = {ControllerId, 24'd0};
          IdxSvr:  rd = 32'(spurious_reg);
          IdxLvt:  rd = 32'(timer_lvt);
          IdxInit: rd = 32'(initial_count);
          IdxCur:  rd = 32'(current_count);
          IdxDiv:  rd = 32'(divide_setting);
          default: rd = 32'd0;
        endcase
      end
      ActWrite: begin
        unique case (reg_index)
          IdxEoi:  interrupt_pending_next = 1'b0;
          IdxSvr:  spurious_reg_next = write_data[8:0];
          IdxLvt:  timer_lvt_next = write_data[17:0] & LvtKeep;
          IdxInit: begin
            // loading the initial count restarts the counter
            initial_count_next  = write_data[CountWidth-1:0];
            current_count_next  = write_data[CountWidth-1:0];
            prescale_count_next = 7'd0;
          end
          IdxDiv:  divide_setting_next = write_data[3:0] & DivKeep;
          default: ;
        endcase
      end
      default: ;  // unknown action leaves everything alone
    endcase

    res_next.read_data  = rd;
    res_next.irq        = interrupt_pending_next;
    res_next.irq_vector = timer_lvt_next[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spurious_reg      <= SvrReset;
      timer_lvt         <= LvtReset;
      initial_count     <= '0;
      current_count     <= '0;
      divide_setting    <= 4'd0;
      prescale_count    <= 7'd0;
      interrupt_pending <= 1'b0;
    end else if (push) begin
      spurious_reg      <= spurious_reg_next;
      timer_lvt         <= timer_lvt_next;
      initial_count     <= initial_count_next;
      current_count     <= current_count_next;
      divide_setting    <= divide_setting_next;
      prescale_count    <= prescale_count_next;
      interrupt_pending <= interrupt_pending_next;
    end
  end

  // new word goes to the result register when it is free or draining,
  // otherwise it parks in the skid register
  assign res_load  = push && (!res_valid || out_ready);
  assign skid_load = push && res_valid && !out_ready;
  assign skid_move = skid_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (res_load || skid_move) begin
        res_valid <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
      if (skid_load) begin
        skid_valid <= 1'b1;
      end else if (skid_move) begin
        skid_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (skid_move) begin
      res_reg <= skid_reg;
    end else if (res_load) begin
      res_reg <= res_next;
    end
    if (skid_load) begin
      skid_reg <= res_next;
    end
  end

  assign out_valid  = res_valid;
  assign read_data  = res_reg.read_data;
  assign irq        = res_reg.irq;
  assign irq_vector = res_reg.irq_vector;

endmodule

`default_nettype wire

// ===== design/lict_checker.sv =====
`default_nettype none

module lict_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] read_data,
  input wire logic        irq,
  input wire logic [7:0]  irq_vector
);

  // no output word right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // input only stalls when a result is waiting
  a_stall_has_word: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // every accepted word leaves a result waiting
  a_accept_gives_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(irq)
      && $stable(irq_vector))
    else $error("stalled result changed");

endmodule

bind local_interrupt_controller_timer_top lict_checker u_lict_checker (.*);

`default_nettype wire
